FILE: hw/rtl/itr_pkg.sv
package itr_pkg;

	localparam int unsigned FRAME_BYTES = 8;
	localparam int unsigned CNT_W       = 12;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_READ  = 2'd1,
		CMD_RESET = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_PROGRESS    = 3'd1,
		ST_COMPLETE    = 3'd2,
		ST_FLOWCTL     = 3'd3,
		ST_SEQERR      = 3'd4,
		ST_OVERFLOW    = 3'd5,
		ST_ERROR       = 3'd6,
		ST_UNSUPPORTED = 3'd7
	} status_t;

	typedef enum logic [3:0] {
		FT_SINGLE      = 4'd0,
		FT_FIRST       = 4'd1,
		FT_CONSECUTIVE = 4'd2,
		FT_FLOW        = 4'd3
	} frame_type_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_COPY,
		S_RESP
	} state_t;

	typedef struct packed {
		logic latch;
		logic decode;
		logic copy;
	} dp_ctrl_t;

	typedef struct packed {
		logic copy_done;
	} dp_stat_t;

endpackage

FILE: hw/rtl/itr_ctrl.sv
module itr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output itr_pkg::dp_ctrl_t ctrl,
	input  itr_pkg::dp_stat_t stat
);
	import itr_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		ctrl      = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.latch = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				ctrl.decode = 1'b1;
				state_d     = S_COPY;
			end
			S_COPY: begin
				if (stat.copy_done) begin
					state_d = S_RESP;
				end else begin
					ctrl.copy = 1'b1;
				end
			end
			S_RESP: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

FILE: hw/rtl/itr_datapath.sv
module itr_datapath #(
	parameter int unsigned BUF_DEPTH = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  itr_pkg::dp_ctrl_t ctrl,
	output itr_pkg::dp_stat_t stat,
	input  logic [1:0]        command,
	input  logic [63:0]       frame_data,
	input  logic [3:0]        frame_len,
	input  logic [11:0]       read_index,
	output logic [2:0]        status,
	output logic [11:0]       payload_length,
	output logic [7:0]        read_byte
);
	import itr_pkg::*;

	localparam int unsigned AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
	localparam logic [CNT_W:0] DEPTH_W = (CNT_W + 1)'(BUF_DEPTH);

	logic [7:0] mem [BUF_DEPTH];

	cmd_code_t        cmd_q;
	logic [63:0]      frame_q;
	logic [3:0]       len_q;
	logic [11:0]      idx_q;

	logic [CNT_W-1:0] rcv_q, exp_q;
	logic [3:0]       seq_q;
	logic [2:0]       copy_q;
	logic [AW-1:0]    wa_q;
	logic [2:0]       bp_q;
	status_t          status_q;
	logic             rd_ok_q;
	logic [7:0]       rdata_q;

	logic [3:0]       ftype, low;
	logic [11:0]      total;
	status_t          st_d;
	logic             clr, store, first_fr, rd_ok_d;
	logic [CNT_W-1:0] exp_d, rcv_d, rcv_base, remaining;
	logic [3:0]       seq_d;
	logic [2:0]       n, first, copy, copy_d;
	logic [CNT_W:0]   sum;

	assign ftype = frame_q[7:4];
	assign low   = frame_q[3:0];
	assign total = {low, frame_q[15:8]};

	always_comb begin
		st_d     = ST_OK;
		clr      = 1'b0;
		store    = 1'b0;
		first_fr = 1'b0;
		rd_ok_d  = 1'b0;
		exp_d    = exp_q;
		seq_d    = seq_q;
		n        = '0;
		first    = 3'd1;
		unique case (cmd_q)
			CMD_ADD: begin
				if (len_q < 4'(FRAME_BYTES)) begin
					st_d = ST_ERROR;
				end else begin
					unique case (ftype)
						FT_SINGLE: begin
							if (low > 4'(FRAME_BYTES - 1)) begin
								st_d = ST_OVERFLOW;
							end else begin
								clr   = 1'b1;
								exp_d = CNT_W'(low);
								store = 1'b1;
								n     = low[2:0];
							end
						end
						FT_FIRST: begin
							if ((CNT_W + 1)'(total) > DEPTH_W) begin
								st_d = ST_OVERFLOW;
							end else begin
								clr      = 1'b1;
								exp_d    = total;
								store    = 1'b1;
								first_fr = 1'b1;
								n        = 3'(FRAME_BYTES - 2);
								first    = 3'd2;
							end
						end
						FT_CONSECUTIVE: begin
							if (low != seq_q) begin
								clr  = 1'b1;
								st_d = ST_SEQERR;
							end else begin
								seq_d = seq_q + 4'd1;
								store = 1'b1;
								n     = 3'(FRAME_BYTES - 1);
							end
						end
						FT_FLOW: st_d = ST_OK;
						default: st_d = ST_UNSUPPORTED;
					endcase
				end
			end
			CMD_READ: begin
				rd_ok_d = (idx_q < rcv_q) && ((CNT_W + 1)'(idx_q) < DEPTH_W);
			end
			CMD_RESET: clr = 1'b1;
			default: st_d = ST_ERROR;
		endcase

		if (clr) begin
			exp_d = store ? exp_d : '0;
			seq_d = 4'd1;
		end
		rcv_base  = clr ? '0 : rcv_q;
		remaining = (exp_d > rcv_base) ? (exp_d - rcv_base) : '0;
		copy      = (CNT_W'(n) > remaining) ? remaining[2:0] : n;
		sum       = (CNT_W + 1)'(rcv_base) + (CNT_W + 1)'(copy);
		rcv_d     = rcv_base;
		copy_d    = '0;
		if (store) begin
			if (sum > DEPTH_W) begin
				st_d = ST_OVERFLOW;
			end else begin
				copy_d = copy;
				rcv_d  = sum[CNT_W-1:0];
				st_d   = (sum[CNT_W-1:0] >= exp_d) ? ST_COMPLETE : ST_PROGRESS;
			end
			if (first_fr && st_d != ST_COMPLETE) begin
				st_d = ST_FLOWCTL;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			cmd_q   <= cmd_code_t'(command);
			frame_q <= frame_data;
			len_q   <= frame_len;
			idx_q   <= read_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_q  <= '0;
			exp_q  <= '0;
			seq_q  <= 4'd1;
			copy_q <= '0;
		end else if (ctrl.decode) begin
			rcv_q  <= rcv_d;
			exp_q  <= exp_d;
			seq_q  <= seq_d;
			copy_q <= copy_d;
		end else if (ctrl.copy) begin
			copy_q <= copy_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.decode) begin
			status_q <= st_d;
			rd_ok_q  <= rd_ok_d;
			wa_q     <= rcv_base[AW-1:0];
			bp_q     <= first;
		end else if (ctrl.copy) begin
			wa_q <= wa_q + AW'(1);
			bp_q <= bp_q + 3'd1;
		end
	end

	// byte store; entries past rcv_q are never read back
	always_ff @(posedge clk) begin
		if (ctrl.copy) begin
			mem[wa_q] <= frame_q[{bp_q, 3'b000} +: 8];
		end
		if (ctrl.decode && rd_ok_d) begin
			rdata_q <= mem[idx_q[AW-1:0]];
		end
	end

	assign stat.copy_done = (copy_q == '0);
	assign status         = status_q;
	assign payload_length = rcv_q;
	assign read_byte      = rd_ok_q ? rdata_q : 8'd0;

endmodule

FILE: hw/rtl/isotp_receive_reassembler_top.sv
// ISO-TP receive reassembly, one beat in and one beat out per command.
// An accepted beat is latched, decoded, has its n frame bytes (0..7) copied and is then
// offered as a result; no new beat is accepted until that result is taken. The byte-wide
// payload store takes one write per cycle.
// Reset (arst_n low, asynchronous): counts cleared, sequence number set to 1;
// stored bytes need no clearing since reads at or past the received count give zero.
module isotp_receive_reassembler_top #(
	parameter int unsigned BUF_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // frame_data[63:0], frame_len[67:64], read_index[79:68]
	input  logic [1:0]  s_tuser,   // command[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // payload_length[11:0], read_byte[19:12], zero[23:20]
	output logic [2:0]  m_tuser    // status[2:0]
);
	import itr_pkg::*;

	dp_ctrl_t    ctrl;
	dp_stat_t    stat;
	logic [11:0] payload_length;
	logic [7:0]  read_byte;

	itr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.ctrl      (ctrl),
		.stat      (stat)
	);

	itr_datapath #(
		.BUF_DEPTH (BUF_DEPTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.stat           (stat),
		.command        (s_tuser),
		.frame_data     (s_tdata[63:0]),
		.frame_len      (s_tdata[67:64]),
		.read_index     (s_tdata[79:68]),
		.status         (m_tuser),
		.payload_length (payload_length),
		.read_byte      (read_byte)
	);

	assign m_tdata = {4'd0, read_byte, payload_length};

endmodule

FILE: bench/isotp_reassembly_checker.sv
`timescale 1ns / 100ps

module isotp_reassembly_checker
	import itr_pkg::*;
#(
	parameter int unsigned BUF_DEPTH = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [79:0] s_tdata,   // frame_data[63:0], frame_len[67:64], read_index[79:68]
	input  logic [1:0]  s_tuser,   // command[1:0]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // payload_length[11:0], read_byte[19:12], zero[23:20]
	input  logic [2:0]  m_tuser,   // status[2:0]
	output int          fail_count,
	output int          pending
);

	typedef struct packed {
		status_t     status;
		logic [11:0] length;
		logic [7:0]  rbyte;
	} reply_t;

	logic [7:0]  payload_mem [BUF_DEPTH];
	int unsigned rx_count;
	int unsigned exp_count;
	logic [3:0]  seq_next;
	reply_t      pending_replies [$];
	reply_t      want;

	function automatic logic [7:0] frame_byte(logic [63:0] d, int unsigned k);
		return d[8 * (k % 8) +: 8];
	endfunction

	function automatic void clear_link();
		for (int i = 0; i < BUF_DEPTH; i++)
			payload_mem[i] = '0;
		rx_count  = 0;
		exp_count = 0;
		seq_next  = 4'd1;
	endfunction

	// copy up to n frame bytes, clipped to what the message still needs
	function automatic status_t store_bytes(logic [63:0] d, int unsigned first, int unsigned n);
		int unsigned remaining;
		int unsigned copy;
		remaining = (exp_count > rx_count) ? exp_count - rx_count : 0;
		copy = (n > remaining) ? remaining : n;
		if (rx_count + copy > BUF_DEPTH)
			return ST_OVERFLOW;
		for (int unsigned k = 0; k < copy; k++)
			payload_mem[rx_count + k] = frame_byte(d, first + k);
		rx_count = (rx_count + copy) & 32'hFFF;
		if (rx_count >= exp_count)
			return ST_COMPLETE;
		return ST_PROGRESS;
	endfunction

	function automatic status_t add_frame(logic [63:0] d, logic [3:0] len);
		logic [3:0]  low;
		int unsigned total;
		status_t     st;
		low = d[3:0];
		if (len < FRAME_BYTES)
			return ST_ERROR;
		case (d[7:4])
			FT_SINGLE: begin
				if (low > FRAME_BYTES - 1)
					return ST_OVERFLOW;
				clear_link();
				exp_count = low;
				return store_bytes(d, 1, low);
			end
			FT_FIRST: begin
				total = {low, d[15:8]};
				if (total > BUF_DEPTH)
					return ST_OVERFLOW;
				clear_link();
				exp_count = total & 32'hFFF;
				st = store_bytes(d, 2, FRAME_BYTES - 2);
				if (st == ST_COMPLETE)
					return ST_COMPLETE;
				return ST_FLOWCTL;
			end
			FT_CONSECUTIVE: begin
				if (low != seq_next) begin
					clear_link();
					return ST_SEQERR;
				end
				seq_next = seq_next + 4'd1;
				return store_bytes(d, 1, FRAME_BYTES - 1);
			end
			FT_FLOW: return ST_OK;
			default: return ST_UNSUPPORTED;
		endcase
	endfunction

	function automatic reply_t predict_reply(cmd_code_t cmd, logic [63:0] d, logic [3:0] len,
			logic [11:0] idx);
		reply_t r;
		r.status = ST_OK;
		r.rbyte  = '0;
		case (cmd)
			CMD_ADD: r.status = add_frame(d, len);
			CMD_READ: begin
				if (idx < rx_count && idx < BUF_DEPTH)
					r.rbyte = payload_mem[idx];
			end
			CMD_RESET: clear_link();
			default: r.status = ST_ERROR;
		endcase
		r.length = rx_count[11:0];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_link();
			pending_replies.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			// result first: it can never belong to a beat accepted at this edge
			if (m_tvalid && m_tready) begin
				if (pending_replies.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: unexpected result beat: status %0d length %0d byte %02h",
							$realtime, m_tuser, m_tdata[11:0], m_tdata[19:12]);
					fail_count++;
				end else begin
					want = pending_replies.pop_front();
					if (want.status != m_tuser || want.length != m_tdata[11:0] ||
							want.rbyte != m_tdata[19:12]) begin
						if (fail_count < 10)
							$display("%0t: mismatch: expected status %0d length %0d byte %02h, got status %0d length %0d byte %02h",
								$realtime, want.status, want.length, want.rbyte,
								m_tuser, m_tdata[11:0], m_tdata[19:12]);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready)
				pending_replies.push_back(predict_reply(cmd_code_t'(s_tuser), s_tdata[63:0],
					s_tdata[67:64], s_tdata[79:68]));
			pending = pending_replies.size();
		end
	end

endmodule

FILE: bench/tb_isotp_receive_reassembler_top.sv
`timescale 1ns / 100ps

module tb_isotp_receive_reassembler_top;
	import itr_pkg::*;

	localparam int unsigned BUF_DEPTH   = 4096;
	localparam int unsigned RAND_ITEMS  = 600;
	localparam int unsigned PHASE_ITEMS = 75;
	localparam int unsigned TAIL_CYCLES = 30;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [79:0] s_tdata;   // frame_data[63:0], frame_len[67:64], read_index[79:68]
	logic [1:0]  s_tuser;   // command[1:0]
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;   // payload_length[11:0], read_byte[19:12], zero[23:20]
	logic [2:0]  m_tuser;   // status[2:0]

	int          fail_count;
	int          pending;
	int unsigned item_count;
	int unsigned idle_pct;
	int unsigned stall_pct;

	isotp_receive_reassembler_top #(
		.BUF_DEPTH(BUF_DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	isotp_reassembly_checker #(
		.BUF_DEPTH(BUF_DEPTH)
	) reassembly_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Test completed with failures");
		$finish;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99, 0) >= stall_pct);
	end

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [3:0] ok_len();
		return 4'($urandom_range(15, 8));
	endfunction

	function automatic logic [63:0] with_head(logic [63:0] body, logic [3:0] ftype,
			logic [3:0] low);
		return {body[63:8], ftype, low};
	endfunction

	function automatic logic [63:0] with_first(logic [63:0] body, logic [11:0] total);
		return {body[63:16], total[7:0], FT_FIRST, total[11:8]};
	endfunction

	task automatic send_beat(cmd_code_t cmd, logic [63:0] d, logic [3:0] len, logic [11:0] idx);
		case ((item_count / PHASE_ITEMS) % 4)
			0: begin
				idle_pct  = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct  = 49;
				stall_pct = 0;
			end
			2: begin
				idle_pct  = 0;
				stall_pct = 49;
			end
			default: begin
				idle_pct  = 27;
				stall_pct = 27;
			end
		endcase
		while ($urandom_range(99, 0) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {idx, len, d};
		s_tuser  <= cmd;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		item_count++;
		@(negedge clk);
	endtask

	task automatic send_add(logic [63:0] d, logic [3:0] len);
		send_beat(CMD_ADD, d, len, 12'($urandom_range(4095, 0)));
	endtask

	task automatic send_read(logic [11:0] idx);
		send_beat(CMD_READ, rnd64(), 4'($urandom_range(15, 0)), idx);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	task automatic send_directed();
		send_read(12'd0);
		send_add(with_head(rnd64(), FT_CONSECUTIVE, 4'd1), 4'd8);   // no message open
		send_add(with_head(rnd64(), FT_CONSECUTIVE, 4'd5), 4'd15);  // bad sequence
		send_add(with_head('0, FT_SINGLE, 4'd0), 4'd8);
		send_add(with_head('1, FT_SINGLE, 4'd7), 4'd15);
		send_read(12'd6);
		send_read(12'd7);
		send_read(12'd4095);
		send_add(with_head(rnd64(), FT_SINGLE, 4'd8), 4'd8);        // single too long
		send_add(with_head(rnd64(), FT_SINGLE, 4'd3), 4'd7);        // short frame
		send_add(rnd64(), 4'd0);
		send_add(with_first(rnd64(), 12'd0), ok_len());
		send_add(with_first(rnd64(), 12'd4095), ok_len());
		send_add(with_head(rnd64(), FT_CONSECUTIVE, 4'd1), ok_len());
		send_add(with_head(rnd64(), FT_CONSECUTIVE, 4'd2), ok_len());
		send_read(12'd12);
		send_add(with_head(rnd64(), FT_FLOW, 4'($urandom_range(15, 0))), ok_len());
		send_add(with_head(rnd64(), 4'd4, 4'd0), ok_len());
		send_add(with_head(rnd64(), 4'd15, 4'd15), ok_len());
		send_beat(CMD_NONE, rnd64(), 4'($urandom_range(15, 0)), 12'($urandom_range(4095, 0)));
		send_beat(CMD_RESET, rnd64(), 4'($urandom_range(15, 0)), 12'($urandom_range(4095, 0)));
		send_read(12'd0);
		send_add(with_first(rnd64(), 12'd5), ok_len());
		send_read(12'd4);
		send_read(12'd5);
		send_add(with_first(rnd64(), 12'd7), ok_len());
		send_add(with_head(rnd64(), FT_CONSECUTIVE, 4'd1), ok_len());
		send_add(with_head(rnd64(), FT_CONSECUTIVE, 4'd2), ok_len());  // past the end
	endtask

	// something inside an open message; keep_going clears when the message is broken
	task automatic send_interlude(int unsigned got, logic [3:0] seq, output bit keep_going);
		keep_going = 1'b1;
		case ($urandom_range(9, 0))
			0, 1, 2, 3: send_read(12'($urandom_range(got + 3, 0)));
			4: send_add(rnd64(), 4'($urandom_range(7, 0)));
			5: send_add(with_head(rnd64(), FT_FLOW, 4'($urandom_range(15, 0))), ok_len());
			6: send_add(with_head(rnd64(), 4'($urandom_range(15, 4)), 4'($urandom_range(15, 0))),
				ok_len());
			7: send_add(with_head(rnd64(), FT_SINGLE, 4'($urandom_range(15, 8))), ok_len());
			8: begin
				keep_going = 1'b0;
				case ($urandom_range(2, 0))
					0: send_add(with_head(rnd64(), FT_CONSECUTIVE,
						seq + 4'($urandom_range(15, 1))), ok_len());
					1: send_beat(CMD_RESET, rnd64(), 4'($urandom_range(15, 0)),
						12'($urandom_range(4095, 0)));
					default: send_add(with_head(rnd64(), FT_SINGLE, 4'($urandom_range(7, 0))),
						ok_len());
				endcase
			end
			default: send_read(12'($urandom_range(4095, 0)));
		endcase
	endtask

	task automatic run_message();
		int unsigned total;
		int unsigned got;
		int unsigned pick;
		logic [3:0]  seq;
		bit          keep_going;
		keep_going = 1'b1;
		if ($urandom_range(99, 0) < 25) begin
			total = $urandom_range(7, 0);
			send_add(with_head(rnd64(), FT_SINGLE, 4'(total)), ok_len());
		end else begin
			pick = $urandom_range(99, 0);
			if (pick < 80)
				total = $urandom_range(60, 0);
			else if (pick < 97)
				total = $urandom_range(300, 61);
			else
				total = $urandom_range(1500, 301);
			send_add(with_first(rnd64(), 12'(total)), ok_len());
			got = (total < 6) ? total : 6;
			seq = 4'd1;
			while (got < total && keep_going) begin
				if ($urandom_range(99, 0) < 12)
					send_interlude(got, seq, keep_going);
				if (keep_going) begin
					send_add(with_head(rnd64(), FT_CONSECUTIVE, seq), ok_len());
					got += 7;
					seq = seq + 4'd1;
				end
			end
		end
		repeat ($urandom_range(3, 0))
			send_read(12'($urandom_range(total + 4, 0)));
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = CMD_NONE;
		item_count = 0;
		idle_pct   = 0;
		stall_pct  = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		send_directed();
		drain();
		item_count = 0;
		while (item_count < RAND_ITEMS) begin
			if ($urandom_range(99, 0) < 75)
				run_message();
			else
				send_beat(cmd_code_t'($urandom_range(3, 0)), rnd64(), 4'($urandom_range(15, 0)),
					12'($urandom_range(4095, 0)));
		end
		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: isotp_receive_reassembler_top.f
hw/rtl/itr_pkg.sv
hw/rtl/itr_ctrl.sv
hw/rtl/itr_datapath.sv
hw/rtl/isotp_receive_reassembler_top.sv
bench/isotp_reassembly_checker.sv
bench/tb_isotp_receive_reassembler_top.sv
